// ===== rtl/core/ps2mc_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet cursor.
// No dependencies; imported by ps2mc_step and ps2_mouse_packet_cursor.
package ps2mc_pkg;

  localparam int unsigned PosW  = 10;
  localparam int unsigned ByteW = 8;

  // Header test: the X/Y sign bits (4 and 5) are masked off before compare
  localparam logic [ByteW-1:0] HDR_MASK   = 8'hCF;
  localparam logic [ByteW-1:0] HDR_NONE   = 8'h08;
  localparam logic [ByteW-1:0] HDR_LEFT   = 8'h09;
  localparam logic [ByteW-1:0] HDR_RIGHT  = 8'h0A;
  // Self-test passed byte followed by device id 0
  localparam logic [ByteW-1:0] ATTACH_BYTE = 8'hAA;
  localparam logic [ByteW-1:0] ATTACH_ID   = 8'h00;

  localparam logic [PosW-1:0] MAX_X_RST = 10'd319;
  localparam logic [PosW-1:0] MAX_Y_RST = 10'd239;

  // Config register indexes
  localparam logic CFG_MAX_X = 1'b0;
  localparam logic CFG_MAX_Y = 1'b1;

  // Item kinds on in_tuser
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_REARM = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,  // nothing to send
    CMD_RESET  = 2'd1,  // send 0xFF
    CMD_ENABLE = 2'd2   // send 0xF4
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] win0;   // older window byte
    logic [ByteW-1:0] win1;   // newer window byte
    logic [PosW-1:0]  cur_x;
    logic [PosW-1:0]  cur_y;
    logic             clicked;
    logic             undo;
    logic             armed;
  } state_t;

  typedef struct packed {
    logic [PosW-1:0] cur_x;
    logic [PosW-1:0] cur_y;
    logic            click;
    logic            undo;
    cmd_t            cmd;
  } result_t;

endpackage

// ===== rtl/core/ps2_mouse_packet_cursor.sv =====
// Top level of the PS/2 mouse packet cursor: stream ports, registers, state.
// Depends on ps2mc_pkg and ps2mc_step.
//
// Takes one received PS/2 byte (or a rearm request) per input word and
// returns one result word per input word: cursor position, latched click and
// undo flags, and a command the host should send to the mouse (none, reset
// 0xFF, or enable reporting 0xF4). A three-byte window (two stored bytes plus
// the incoming one) is scanned for a header with bit 3 set, bits 6/7 clear and
// buttons none, left or right; the two bytes after it are signed X and Y
// deltas. X is added, Y subtracted, and both saturate to 0..max. A left or
// right click latches the flags and ignores further bytes until a rearm word.
// The block takes one word per clock while the result stream is not stalled:
// the decoder state is updated in the same cycle a word leaves the input
// register, so consecutive words never wait on each other. A result word
// passes the input register and then the result register. When the result
// register is stalled, the input register still holds one word, so the
// block absorbs one extra word before dropping in_tready. max_x/max_y should
// be written through the cfg port only while the block is idle; the block
// itself does not enforce this. They reset to 319 and 239.
module ps2_mouse_packet_cursor
  import ps2mc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic             in_tuser,   // [0] action: 0 byte, 1 rearm
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // [9:0] cursor_x, [19:10] cursor_y,
                                       // [20] click_flag, [21] undo_flag,
                                       // [23:22] send_command
  // config write port
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [PosW-1:0]  cfg_wdata
);

  // input register
  logic             s1_valid_r;
  logic             s1_action_r;
  logic [ByteW-1:0] s1_byte_r;
  // result register
  logic             out_valid_r;
  result_t          out_res_r;
  // decoder state and config
  state_t           st_r;
  state_t           st_nxt;
  result_t          res_nxt;
  logic [PosW-1:0]  max_x_r;
  logic [PosW-1:0]  max_y_r;

  logic s1_adv;   // word moves from input register into result register
  logic in_acc;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  ps2mc_step u_step (
    .cur     (st_r),
    .action  (s1_action_r),
    .rx_byte (s1_byte_r),
    .max_x   (max_x_r),
    .max_y   (max_y_r),
    .nxt     (st_nxt),
    .res     (res_nxt)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{win0: '0, win1: '0, cur_x: '0, cur_y: '0,
                       clicked: 1'b0, undo: 1'b0, armed: 1'b1};
      max_x_r     <= MAX_X_RST;
      max_y_r     <= MAX_Y_RST;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MAX_X: max_x_r <= cfg_wdata;
          CFG_MAX_Y: max_y_r <= cfg_wdata;
          default:   ;
        endcase
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_tuser;
      s1_byte_r   <= in_tdata;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.cmd, out_res_r.undo, out_res_r.click,
                       out_res_r.cur_y, out_res_r.cur_x};

`ifndef ASSERT_OFF
  // Disarmed means a click was latched
  a_disarm_clicked: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.armed |-> st_r.clicked)
    else $error("disarmed without click flag");

  // Undo never appears without click
  a_undo_click: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.undo |-> st_r.clicked)
    else $error("undo flag set without click flag");

  // A rearm word always reports the reset command and clears the flags
  a_rearm_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == ACT_REARM) |=>
      (out_res_r.cmd == CMD_RESET && !st_r.clicked && st_r.armed))
    else $error("rearm did not report reset command");

  // Bytes are ignored while disarmed
  a_disarmed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == ACT_BYTE && !st_r.armed) |=>
      ($stable(st_r) && out_res_r.cmd == CMD_NONE))
    else $error("state changed while disarmed");
`endif

endmodule

// ===== rtl/core/ps2mc_step.sv =====
// Combinational next-state and result logic for one word.
// Depends on ps2mc_pkg.
module ps2mc_step
  import ps2mc_pkg::*;
(
  input  state_t           cur,
  input  logic             action,
  input  logic [ByteW-1:0] rx_byte,
  input  logic [PosW-1:0]  max_x,
  input  logic [PosW-1:0]  max_y,
  output state_t           nxt,
  output result_t          res
);

  logic [ByteW-1:0] hdr;
  logic             is_hdr;
  logic             is_attach;
  logic [PosW+1:0]  x_sum;
  logic [PosW+1:0]  y_sum;
  logic [PosW-1:0]  x_sat;
  logic [PosW-1:0]  y_sat;
  cmd_t             cmd;

  assign hdr       = cur.win0 & HDR_MASK;
  assign is_hdr    = hdr inside {HDR_NONE, HDR_LEFT, HDR_RIGHT};
  assign is_attach = (cur.win1 == ATTACH_BYTE) && (rx_byte == ATTACH_ID);

  // 12-bit signed sums: position plus or minus a sign-extended delta
  assign x_sum = {2'b00, cur.cur_x} + {{(PosW+2-ByteW){cur.win1[ByteW-1]}}, cur.win1};
  assign y_sum = {2'b00, cur.cur_y} - {{(PosW+2-ByteW){rx_byte[ByteW-1]}}, rx_byte};

  always_comb begin
    if (x_sum[PosW+1]) begin
      x_sat = '0;
    end else if (x_sum[PosW:0] > {1'b0, max_x}) begin
      x_sat = max_x;
    end else begin
      x_sat = x_sum[PosW-1:0];
    end
    if (y_sum[PosW+1]) begin
      y_sat = '0;
    end else if (y_sum[PosW:0] > {1'b0, max_y}) begin
      y_sat = max_y;
    end else begin
      y_sat = y_sum[PosW-1:0];
    end
  end

  always_comb begin
    nxt = cur;
    cmd = CMD_NONE;
    if (action == ACT_REARM) begin
      nxt.clicked = 1'b0;
      nxt.undo    = 1'b0;
      nxt.armed   = 1'b1;
      cmd         = CMD_RESET;
    end else if (cur.armed) begin
      if (is_attach) begin
        cmd = CMD_ENABLE;
      end else if (is_hdr) begin
        if (hdr == HDR_RIGHT) begin
          nxt.undo = 1'b1;
        end else begin
          nxt.cur_x = x_sat;
          nxt.cur_y = y_sat;
        end
        if (hdr != HDR_NONE) begin
          nxt.clicked = 1'b1;
          nxt.armed   = 1'b0;
        end
        nxt.win0 = '0;
        nxt.win1 = '0;
      end else begin
        nxt.win0 = cur.win1;
        nxt.win1 = rx_byte;
      end
    end
  end

  assign res.cur_x = nxt.cur_x;
  assign res.cur_y = nxt.cur_y;
  assign res.click = nxt.clicked;
  assign res.undo  = nxt.undo;
  assign res.cmd   = cmd;

endmodule
